// File: src/prxyz_pkg.sv
// prxyz_pkg: widths, register indexes and shared types for the point rotator.
// Used by the interfaces, the trig units, the rotation cells and the top level.
package prxyz_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ANGLE_BITS  = 12;
  localparam int FRAC_BITS   = 14;

  localparam int OUT_WIDTH   = COORD_WIDTH + 2;
  // internal coordinate width, headroom over the norm growth of three stages
  localparam int INT_WIDTH   = COORD_WIDTH + 3;
  // signed sine / cosine, range -2^FRAC_BITS .. 2^FRAC_BITS
  localparam int TRIG_WIDTH  = FRAC_BITS + 2;
  localparam int QUARTER     = 1 << (ANGLE_BITS - 2);

  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z = 2'd2;

  typedef logic [ANGLE_BITS-1:0]         angle_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_WIDTH-1:0]   ocoord_t;
  typedef logic signed [INT_WIDTH-1:0]   icoord_t;
  typedef logic signed [TRIG_WIDTH-1:0]  trig_t;

  // what one rotation cell hands to the next
  typedef struct packed {
    logic    vld;
    icoord_t u;
    icoord_t v;
    icoord_t p;
  } cell_word_t;

endpackage

// File: src/prxyz_if.sv
// prxyz_if: valid/ready channel interfaces for points in, points out and register writes.
// Depends on prxyz_pkg for field widths.
interface prxyz_in_if;
  logic                 valid;
  logic                 ready;
  prxyz_pkg::coord_t    in_x;
  prxyz_pkg::coord_t    in_y;
  prxyz_pkg::coord_t    in_z;
  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface prxyz_out_if;
  logic                 valid;
  logic                 ready;
  prxyz_pkg::ocoord_t   out_x;
  prxyz_pkg::ocoord_t   out_y;
  prxyz_pkg::ocoord_t   out_z;
  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

interface prxyz_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [prxyz_pkg::CFG_IDX_W-1:0]      index;
  logic [prxyz_pkg::ANGLE_BITS-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/prxyz_trig.sv
// prxyz_trig: sine and cosine of one binary angle from a quarter-wave ROM.
// ROM contents are computed at elaboration; depends on prxyz_pkg.
module prxyz_trig (
  input  logic               clk_i,
  input  prxyz_pkg::angle_t  angle_i,
  input  logic               neg_sin_i,
  output prxyz_pkg::trig_t   cos_o,
  output prxyz_pkg::trig_t   sin_o
);

  localparam int AB = prxyz_pkg::ANGLE_BITS;
  localparam int FB = prxyz_pkg::FRAC_BITS;
  localparam int QT = prxyz_pkg::QUARTER;
  localparam longint unsigned PI_HALF_Q61 = 64'h3243F6A8885A308D;

  typedef logic [FB:0] rom_word_t;
  typedef rom_word_t sin_rom_t [0:QT];

  // (a*b) >> 61 in Q61
  function automatic longint unsigned mul_q61(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[124:61];
  endfunction

  // restoring long division, used only while building the ROM
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series to fifteen terms, rounded to FB fraction bits
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t        rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned kk;
    longint unsigned nn;
    for (int k = 0; k < QT; k++) begin
      kk   = longint'(k);
      x    = (PI_HALF_Q61 >> (AB - 2)) * kk
           + (((PI_HALF_Q61 & longint'(QT - 1)) * kk) >> (AB - 2));
      x2   = mul_q61(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 14; n++) begin
        nn   = longint'(n);
        term = udiv64(mul_q61(term, x2), (2 * nn) * (2 * nn + 1));
        if (nn[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      sum    = (sum + (64'd1 << (61 - FB - 1))) >> (61 - FB);
      rom[k] = sum[FB:0];
    end
    rom[QT] = rom_word_t'(1 << FB);
    return rom;
  endfunction

  localparam sin_rom_t SinRom = build_sin_rom();

  prxyz_pkg::angle_t cos_ang;
  logic [AB-2:0]     sin_idx;
  logic [AB-2:0]     cos_idx;

  rom_word_t sin_raw_q;
  rom_word_t cos_raw_q;
  logic      sin_neg_q;
  logic      cos_neg_q;
  prxyz_pkg::trig_t sin_q;
  prxyz_pkg::trig_t cos_q;
  prxyz_pkg::trig_t sin_d;
  prxyz_pkg::trig_t cos_d;

  assign cos_ang = angle_i + prxyz_pkg::angle_t'(QT);

  // odd quadrants read the table backward
  assign sin_idx = angle_i[AB-2] ? ((AB-1)'(QT) - {1'b0, angle_i[AB-3:0]})
                                 : {1'b0, angle_i[AB-3:0]};
  assign cos_idx = cos_ang[AB-2] ? ((AB-1)'(QT) - {1'b0, cos_ang[AB-3:0]})
                                 : {1'b0, cos_ang[AB-3:0]};

  always_ff @(posedge clk_i) begin
    sin_raw_q <= SinRom[sin_idx];
    cos_raw_q <= SinRom[cos_idx];
    sin_neg_q <= angle_i[AB-1];
    cos_neg_q <= cos_ang[AB-1];
  end

  always_comb begin
    sin_d = prxyz_pkg::trig_t'({1'b0, sin_raw_q});
    cos_d = prxyz_pkg::trig_t'({1'b0, cos_raw_q});
    if (sin_neg_q ^ neg_sin_i) begin
      sin_d = -sin_d;
    end
    if (cos_neg_q) begin
      cos_d = -cos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sin_q <= sin_d;
    cos_q <= cos_d;
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: src/prxyz_cell.sv
// prxyz_cell: one plane rotation, u = a*c - b*s, v = a*s + b*c, truncated toward zero.
// Two register stages: products, then sums. Depends on prxyz_pkg.
module prxyz_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  prxyz_pkg::cell_word_t  word_i,
  input  prxyz_pkg::trig_t       cos_i,
  input  prxyz_pkg::trig_t       sin_i,
  output prxyz_pkg::cell_word_t  word_o
);

  localparam int IW = prxyz_pkg::INT_WIDTH;
  localparam int FB = prxyz_pkg::FRAC_BITS;
  localparam int PW = prxyz_pkg::INT_WIDTH + prxyz_pkg::TRIG_WIDTH;
  localparam int SW = PW + 1;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  // stage 1: products
  logic  v1_q;
  prod_t ac_q, bs_q, as_q, bc_q;
  prxyz_pkg::icoord_t p1_q;

  // stage 2: truncated sums
  logic  v2_q;
  prxyz_pkg::icoord_t u_q, v_q, p2_q;
  prxyz_pkg::icoord_t u_d, v_d;

  sum_t su, sv, tu, tv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= word_i.vld;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= word_i.u * cos_i;
      bs_q <= word_i.v * sin_i;
      as_q <= word_i.u * sin_i;
      bc_q <= word_i.v * cos_i;
      p1_q <= word_i.p;
      u_q  <= u_d;
      v_q  <= v_d;
      p2_q <= p1_q;
    end
  end

  always_comb begin
    su = {ac_q[PW-1], ac_q} - {bs_q[PW-1], bs_q};
    sv = {as_q[PW-1], as_q} + {bc_q[PW-1], bc_q};
    // bias negatives so the arithmetic shift rounds toward zero
    tu = su + {{(SW-FB){1'b0}}, {FB{su[SW-1]}}};
    tv = sv + {{(SW-FB){1'b0}}, {FB{sv[SW-1]}}};
    u_d = tu[FB+IW-1:FB];
    v_d = tv[FB+IW-1:FB];
  end

  assign word_o.vld = v2_q;
  assign word_o.u   = u_q;
  assign word_o.v   = v_q;
  assign word_o.p   = p2_q;

endmodule

// File: src/point_rotate_xyz_top.sv
// point_rotate_xyz_top: X, then Y, then Z rotation of a point as a chain of three cells.
// Depends on prxyz_pkg, prxyz_if, prxyz_trig and prxyz_cell.
//
//  channel   dir  handshake      word
//  pnt_in    in   valid/ready    in_x, in_y, in_z (16 b signed)
//  pnt_out   out  valid/ready    out_x, out_y, out_z (18 b signed, saturated)
//  cfg       in   valid/ready    index (0 x, 1 y, 2 z), data (12 b angle)
//
// One point per cycle when not stalled; seven register stages (two per cell, one output
// register) lie between accepting edge and out valid. The whole chain advances together
// and stalls while a result waits on pnt_out. After reset and after each register write,
// pnt_in is not ready while the sine ROM reads and sign stages refill.
module point_rotate_xyz_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  prxyz_in_if.sink     pnt_in,
  prxyz_out_if.source  pnt_out,
  prxyz_cfg_if.sink    cfg
);

  localparam int IW = prxyz_pkg::INT_WIDTH;
  localparam int CW = prxyz_pkg::COORD_WIDTH;
  localparam int OW = prxyz_pkg::OUT_WIDTH;

  prxyz_pkg::angle_t angle_x_q, angle_y_q, angle_z_q;
  logic [1:0]        settle_q;
  logic              cfg_wr;
  logic              advance;
  logic              in_acc;

  logic              out_vld_q;
  prxyz_pkg::ocoord_t out_x_q, out_y_q, out_z_q;

  prxyz_pkg::trig_t  cx, sx, cy, sy, cz, sz;
  prxyz_pkg::cell_word_t wx_i, wx_o, wy_i, wy_o, wz_i, wz_o;

  function automatic prxyz_pkg::ocoord_t sat_out(prxyz_pkg::icoord_t v);
    if (v[IW-1:OW-1] == {(IW-OW+1){v[IW-1]}}) begin
      return v[OW-1:0];
    end else if (v[IW-1]) begin
      return {1'b1, {(OW-1){1'b0}}};
    end else begin
      return {1'b0, {(OW-1){1'b1}}};
    end
  endfunction

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q <= '0;
      angle_y_q <= '0;
      angle_z_q <= '0;
      settle_q  <= 2'd2;
    end else begin
      if (cfg_wr) begin
        settle_q <= 2'd2;
        case (cfg.index)
          prxyz_pkg::CFG_ANGLE_X: angle_x_q <= cfg.data;
          prxyz_pkg::CFG_ANGLE_Y: angle_y_q <= cfg.data;
          prxyz_pkg::CFG_ANGLE_Z: angle_z_q <= cfg.data;
          default: ;
        endcase
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  assign advance      = !out_vld_q || pnt_out.ready;
  assign pnt_in.ready = advance && (settle_q == 2'd0) && !cfg_wr;
  assign in_acc       = pnt_in.valid && pnt_in.ready;

  // Y and Z stages use the opposite sine sign
  prxyz_trig u_trig_x (.clk_i, .angle_i(angle_x_q), .neg_sin_i(1'b0), .cos_o(cx), .sin_o(sx));
  prxyz_trig u_trig_y (.clk_i, .angle_i(angle_y_q), .neg_sin_i(1'b1), .cos_o(cy), .sin_o(sy));
  prxyz_trig u_trig_z (.clk_i, .angle_i(angle_z_q), .neg_sin_i(1'b1), .cos_o(cz), .sin_o(sz));

  // X cell rotates (y, z), x passes
  assign wx_i.vld = in_acc;
  assign wx_i.u   = {{(IW-CW){pnt_in.in_y[CW-1]}}, pnt_in.in_y};
  assign wx_i.v   = {{(IW-CW){pnt_in.in_z[CW-1]}}, pnt_in.in_z};
  assign wx_i.p   = {{(IW-CW){pnt_in.in_x[CW-1]}}, pnt_in.in_x};

  prxyz_cell u_cell_x (.clk_i, .rst_ni, .en_i(advance), .word_i(wx_i),
                       .cos_i(cx), .sin_i(sx), .word_o(wx_o));

  // Y cell rotates (x, z), y passes
  assign wy_i.vld = wx_o.vld;
  assign wy_i.u   = wx_o.p;
  assign wy_i.v   = wx_o.v;
  assign wy_i.p   = wx_o.u;

  prxyz_cell u_cell_y (.clk_i, .rst_ni, .en_i(advance), .word_i(wy_i),
                       .cos_i(cy), .sin_i(sy), .word_o(wy_o));

  // Z cell rotates (x, y), z passes
  assign wz_i.vld = wy_o.vld;
  assign wz_i.u   = wy_o.u;
  assign wz_i.v   = wy_o.p;
  assign wz_i.p   = wy_o.v;

  prxyz_cell u_cell_z (.clk_i, .rst_ni, .en_i(advance), .word_i(wz_i),
                       .cos_i(cz), .sin_i(sz), .word_o(wz_o));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= wz_o.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_x_q <= sat_out(wz_o.u);
      out_y_q <= sat_out(wz_o.v);
      out_z_q <= sat_out(wz_o.p);
    end
  end

  assign pnt_out.valid = out_vld_q;
  assign pnt_out.out_x = out_x_q;
  assign pnt_out.out_y = out_y_q;
  assign pnt_out.out_z = out_z_q;

endmodule

// File: src/prxyz_checker.sv
// prxyz_checker: port-level assertions for point_rotate_xyz_top, bound to the top level.
// Depends on prxyz_pkg for field widths.
module prxyz_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input prxyz_pkg::ocoord_t out_x_i,
  input prxyz_pkg::ocoord_t out_y_i,
  input prxyz_pkg::ocoord_t out_z_i,
  input logic               cfg_valid_i,
  input logic               cfg_ready_i
);

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i)
                                    && $stable(out_z_i))
    else $error("stalled output word changed");

  // chain does not take a point while a result is stalled
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input ready while output stalled");

  // trig tables refill after a register write
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("input ready before angle settled");

  // no point taken in the same cycle as a register write
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("point accepted during register write");

endmodule

bind point_rotate_xyz_top prxyz_checker u_prxyz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pnt_in.valid),
  .in_ready_i  (pnt_in.ready),
  .out_valid_i (pnt_out.valid),
  .out_ready_i (pnt_out.ready),
  .out_x_i     (pnt_out.out_x),
  .out_y_i     (pnt_out.out_y),
  .out_z_i     (pnt_out.out_z),
  .cfg_valid_i (cfg.valid),
  .cfg_ready_i (cfg.ready)
);
